### hdl/lca_pkg.sv
// shared constants, codes, types and helpers of the lowest common ancestor engine
package lca_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int NODE_W     = 10;
  localparam int CNT_W      = 11;
  localparam int DEPTH_W    = 10;
  localparam int LOG_LEVELS = 11;
  localparam int LVL_W      = 4;
  localparam int EDGE_SLOTS = 2 * (MAX_NODES - 1);
  localparam int EDGE_W     = 11;
  localparam int TOUR_MAX   = 2 * MAX_NODES;
  localparam int TOUR_W     = 11;
  localparam int LEN_W      = 12;
  localparam int TBL_DEPTH  = LOG_LEVELS * TOUR_MAX;
  localparam int TBL_AW     = LVL_W + TOUR_W;

  localparam logic [EDGE_W-1:0] LINK_EMPTY = EDGE_W'(EDGE_SLOTS);

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_BUILD,
    CMD_QUERY,
    CMD_CLEAR
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NOT_BUILT,
    ST_RANGE,
    ST_FULL
  } status_e;

  typedef enum logic [0:0] {
    REG_NODE_COUNT,
    REG_ROOT_NODE
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_ADD1,
    S_ADD2,
    S_ADD3,
    S_BINIT,
    S_BROOT,
    S_WALK,
    S_EDGE,
    S_VISIT,
    S_POP,
    S_SPARSE,
    S_Q1,
    S_Q2,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [NODE_W-1:0]  node;
  } tbl_entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    tbl_entry_t        wdata;
    logic [TBL_AW-1:0] raddr_a;
    logic [TBL_AW-1:0] raddr_b;
  } tbl_req_t;

  typedef struct packed {
    logic [EDGE_W-1:0] next;
    logic [NODE_W-1:0] target;
  } edge_t;

  typedef struct packed {
    logic [NODE_W-1:0]  node;
    logic [EDGE_W-1:0]  link;
    logic [DEPTH_W-1:0] depth;
  } stk_t;

  // later entry wins a tie
  function automatic tbl_entry_t pick_min(tbl_entry_t x, tbl_entry_t y);
    return (x.depth < y.depth) ? x : y;
  endfunction

endpackage

### hdl/lca_if.sv
// valid/ready channel interfaces for command items and result items
interface lca_in_if import lca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source (output valid, cmd, node_a, node_b, input ready);
  modport sink (input valid, cmd, node_a, node_b, output ready);
endinterface

interface lca_out_if import lca_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [NODE_W-1:0] ancestor;
  logic [CNT_W-1:0]  distance;
  modport source (output valid, status, ancestor, distance, input ready);
  modport sink (input valid, status, ancestor, distance, output ready);
endinterface

### hdl/lowest_common_ancestor_engine.sv
// top level: command sequencer, adjacency store, depth walk and query logic
// add edge, query, clear and build each run to completion, one item at a time
// build: a sweep over the n nodes, then a walk over the edge entries with pops,
// then the sparse table entries level by level through the table port
// reset: control state clears at once, then a pass over every adjacency head
// empties them, during which no item is accepted
module lowest_common_ancestor_engine import lca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  lca_in_if.sink           in_i,
  lca_out_if.source        out_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [CNT_W-1:0]   sp_q, sp_d;
  logic               built_q, built_d;
  logic [EDGE_W-1:0]  edges_q, edges_d;
  logic [CNT_W-1:0]   node_count_q, node_count_d;
  logic [NODE_W-1:0]  root_q, root_d;
  logic               pend_q, pend_d;
  logic [TBL_AW-1:0]  pend_addr_q, pend_addr_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q, out_status_d;
  logic [NODE_W-1:0]  out_anc_q, out_anc_d;
  logic [CNT_W-1:0]   out_dist_q, out_dist_d;
  logic [NODE_W-1:0]  a_q, a_d, b_q, b_d;
  logic [NODE_W-1:0]  cur_u_q, cur_u_d, v_q, v_d;
  logic [EDGE_W-1:0]  cur_e_q, cur_e_d;
  logic [DEPTH_W-1:0] cur_d_q, cur_d_d;
  logic [CNT_W-1:0]   sum_q, sum_d;
  logic [1:0]         res_status_q, res_status_d;
  logic [NODE_W-1:0]  res_anc_q, res_anc_d;
  logic [CNT_W-1:0]   res_dist_q, res_dist_d;

  logic [CNT_W-1:0]   n_eff;
  logic               in_ready;

  logic               head_we;
  logic [NODE_W-1:0]  head_waddr, head_raddr;
  logic [EDGE_W-1:0]  head_wdata, head_rd_q;
  logic [EDGE_W-1:0]  head_mem [MAX_NODES];

  logic               edge_we;
  logic [EDGE_W-1:0]  edge_waddr;
  edge_t              edge_wdata, edge_rd_q;
  edge_t              edge_mem [EDGE_SLOTS];

  logic               depth_we;
  logic [NODE_W-1:0]  depth_waddr;
  logic [DEPTH_W-1:0] depth_wdata, depth_rd_a_q, depth_rd_b_q;
  logic [DEPTH_W-1:0] depth_mem [MAX_NODES];

  logic               tpos_we;
  logic [NODE_W-1:0]  tpos_waddr;
  logic [TOUR_W-1:0]  tpos_wdata, tpos_rd_a_q, tpos_rd_b_q;
  logic [TOUR_W-1:0]  tpos_mem [MAX_NODES];

  logic               reach_we, reach_wdata, reach_rd_q;
  logic [NODE_W-1:0]  reach_waddr;
  logic               reach_mem [MAX_NODES];

  logic               stk_we;
  logic [NODE_W-1:0]  stk_waddr, stk_raddr;
  stk_t               stk_wdata, stk_rd_q;
  stk_t               stk_mem [MAX_NODES];

  logic               app_en;
  logic [NODE_W-1:0]  app_node;
  logic [DEPTH_W-1:0] app_depth;

  tbl_req_t           tbl_req;
  tbl_entry_t         tbl_pick;

  logic [CNT_W-1:0]   sp_dec, sp_dec2;

  assign n_eff = (node_count_q == '0) ? CNT_W'(1) :
                 (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
  assign sp_dec  = sp_q - CNT_W'(1);
  assign sp_dec2 = sp_q - CNT_W'(2);
  assign stk_raddr = sp_dec2[NODE_W-1:0];

  lca_table u_table (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .pick_o (tbl_pick)
  );

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_q <= head_mem[head_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd_q <= edge_mem[cur_e_q];
  end

  always_ff @(posedge clk_i) begin
    if (depth_we) begin
      depth_mem[depth_waddr] <= depth_wdata;
    end
    depth_rd_a_q <= depth_mem[in_i.node_a];
    depth_rd_b_q <= depth_mem[in_i.node_b];
  end

  always_ff @(posedge clk_i) begin
    if (tpos_we) begin
      tpos_mem[tpos_waddr] <= tpos_wdata;
    end
    tpos_rd_a_q <= tpos_mem[in_i.node_a];
    tpos_rd_b_q <= tpos_mem[in_i.node_b];
  end

  always_ff @(posedge clk_i) begin
    if (reach_we) begin
      reach_mem[reach_waddr] <= reach_wdata;
    end
    reach_rd_q <= reach_mem[edge_rd_q.target];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      lvl_q        <= '0;
      len_q        <= '0;
      sp_q         <= '0;
      built_q      <= 1'b0;
      edges_q      <= '0;
      node_count_q <= CNT_W'(1);
      root_q       <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      lvl_q        <= lvl_d;
      len_q        <= len_d;
      sp_q         <= sp_d;
      built_q      <= built_d;
      edges_q      <= edges_d;
      node_count_q <= node_count_d;
      root_q       <= root_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_addr_q  <= pend_addr_d;
    out_status_q <= out_status_d;
    out_anc_q    <= out_anc_d;
    out_dist_q   <= out_dist_d;
    a_q          <= a_d;
    b_q          <= b_d;
    cur_u_q      <= cur_u_d;
    cur_e_q      <= cur_e_d;
    cur_d_q      <= cur_d_d;
    v_q          <= v_d;
    sum_q        <= sum_d;
    res_status_q <= res_status_d;
    res_anc_q    <= res_anc_d;
    res_dist_q   <= res_dist_d;
  end

  always_comb begin
    logic [TOUR_W-1:0]  pu, pv;
    logic [LEN_W-1:0]   w, span, half;
    logic [LVL_W-1:0]   qlvl;
    logic [CNT_W-1:0]   twice;
    state_d      = state_q;
    cnt_d        = cnt_q;
    lvl_d        = lvl_q;
    len_d        = len_q;
    sp_d         = sp_q;
    built_d      = built_q;
    edges_d      = edges_q;
    node_count_d = node_count_q;
    root_d       = root_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_anc_d    = out_anc_q;
    out_dist_d   = out_dist_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_u_d      = cur_u_q;
    cur_e_d      = cur_e_q;
    cur_d_d      = cur_d_q;
    v_d          = v_q;
    sum_d        = sum_q;
    res_status_d = res_status_q;
    res_anc_d    = res_anc_q;
    res_dist_d   = res_dist_q;
    in_ready     = 1'b0;
    head_we      = 1'b0;
    head_waddr   = a_q;
    head_wdata   = LINK_EMPTY;
    head_raddr   = in_i.node_a;
    edge_we      = 1'b0;
    edge_waddr   = edges_q;
    edge_wdata   = '{next: head_rd_q, target: b_q};
    depth_we     = 1'b0;
    depth_waddr  = cnt_q[NODE_W-1:0];
    depth_wdata  = '0;
    tpos_we      = 1'b0;
    tpos_waddr   = cnt_q[NODE_W-1:0];
    tpos_wdata   = '0;
    reach_we     = 1'b0;
    reach_waddr  = cnt_q[NODE_W-1:0];
    reach_wdata  = 1'b0;
    stk_we       = 1'b0;
    stk_waddr    = sp_dec[NODE_W-1:0];
    stk_wdata    = '{node: cur_u_q, link: cur_e_q, depth: cur_d_q};
    app_en       = 1'b0;
    app_node     = root_q;
    app_depth    = '0;
    tbl_req      = '0;
    pu           = (tpos_rd_a_q > tpos_rd_b_q) ? tpos_rd_b_q : tpos_rd_a_q;
    pv           = (tpos_rd_a_q > tpos_rd_b_q) ? tpos_rd_a_q : tpos_rd_b_q;
    w            = LEN_W'(pv) - LEN_W'(pu) + LEN_W'(1);
    qlvl         = '0;
    for (int k = 1; k < LOG_LEVELS; k++) begin
      if (w >= (LEN_W'(1) << k)) qlvl = LVL_W'(k);
    end
    span         = LEN_W'(1) << lvl_q;
    half         = span >> 1;
    twice        = {tbl_pick.depth, 1'b0};

    case (state_q)
      S_INIT, S_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = cnt_q[NODE_W-1:0];
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(MAX_NODES - 1)) begin
          cnt_d   = '0;
          state_d = (state_q == S_INIT) ? S_IDLE : S_RESP;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          a_d          = in_i.node_a;
          b_d          = in_i.node_b;
          res_status_d = ST_OK;
          res_anc_d    = '0;
          res_dist_d   = '0;
          state_d      = S_RESP;
          case (cmd_e'(in_i.cmd))
            CMD_ADD: begin
              if ({1'b0, in_i.node_a} >= n_eff || {1'b0, in_i.node_b} >= n_eff) begin
                res_status_d = ST_RANGE;
              end else if (edges_q > EDGE_W'(EDGE_SLOTS - 2)) begin
                res_status_d = ST_FULL;
              end else begin
                state_d = S_ADD1;
              end
            end
            CMD_BUILD: begin
              if ({1'b0, root_q} >= n_eff) begin
                res_status_d = ST_RANGE;
                built_d      = 1'b0;
              end else begin
                cnt_d   = '0;
                state_d = S_BINIT;
              end
            end
            CMD_QUERY: begin
              if (!built_q) begin
                res_status_d = ST_NOT_BUILT;
              end else if ({1'b0, in_i.node_a} >= n_eff ||
                           {1'b0, in_i.node_b} >= n_eff) begin
                res_status_d = ST_RANGE;
              end else begin
                state_d = S_Q1;
              end
            end
            CMD_CLEAR: begin
              cnt_d   = '0;
              edges_d = '0;
              state_d = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_ADD1: begin
        edge_we    = 1'b1;
        head_we    = 1'b1;
        head_wdata = edges_q;
        state_d    = S_ADD2;
      end
      S_ADD2: begin
        head_raddr = b_q;
        state_d    = S_ADD3;
      end
      S_ADD3: begin
        edge_we    = 1'b1;
        edge_waddr = edges_q + EDGE_W'(1);
        edge_wdata = '{next: head_rd_q, target: a_q};
        head_we    = 1'b1;
        head_waddr = b_q;
        head_wdata = edges_q + EDGE_W'(1);
        edges_d    = edges_q + EDGE_W'(2);
        state_d    = S_RESP;
      end
      S_BINIT: begin
        depth_we   = 1'b1;
        tpos_we    = 1'b1;
        reach_we   = 1'b1;
        head_raddr = root_q;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == n_eff - CNT_W'(1)) begin
          len_d   = '0;
          state_d = S_BROOT;
        end
      end
      S_BROOT: begin
        cur_u_d     = root_q;
        cur_e_d     = head_rd_q;
        cur_d_d     = '0;
        sp_d        = CNT_W'(1);
        reach_we    = 1'b1;
        reach_waddr = root_q;
        reach_wdata = 1'b1;
        app_en      = 1'b1;
        state_d     = S_WALK;
      end
      S_WALK: begin
        if (cur_e_q >= LINK_EMPTY) begin
          sp_d = sp_dec;
          if (sp_q > CNT_W'(1)) begin
            state_d = S_POP;
          end else begin
            lvl_d   = LVL_W'(1);
            cnt_d   = '0;
            state_d = S_SPARSE;
          end
        end else begin
          state_d = S_EDGE;
        end
      end
      S_EDGE: begin
        v_d        = edge_rd_q.target;
        cur_e_d    = edge_rd_q.next;
        head_raddr = edge_rd_q.target;
        state_d    = S_VISIT;
      end
      S_VISIT: begin
        state_d = S_WALK;
        if ({1'b0, v_q} < n_eff && !reach_rd_q && sp_q < CNT_W'(MAX_NODES)) begin
          stk_we      = 1'b1;
          cur_u_d     = v_q;
          cur_d_d     = cur_d_q + DEPTH_W'(1);
          cur_e_d     = head_rd_q;
          sp_d        = sp_q + CNT_W'(1);
          depth_we    = 1'b1;
          depth_waddr = v_q;
          depth_wdata = cur_d_q + DEPTH_W'(1);
          reach_we    = 1'b1;
          reach_waddr = v_q;
          reach_wdata = 1'b1;
          app_en      = 1'b1;
          app_node    = v_q;
          app_depth   = cur_d_q + DEPTH_W'(1);
        end
      end
      S_POP: begin
        cur_u_d   = stk_rd_q.node;
        cur_e_d   = stk_rd_q.link;
        cur_d_d   = stk_rd_q.depth;
        app_en    = 1'b1;
        app_node  = stk_rd_q.node;
        app_depth = stk_rd_q.depth;
        state_d   = S_WALK;
      end
      S_SPARSE: begin
        if (lvl_q < LVL_W'(LOG_LEVELS) && span <= len_q) begin
          if (LEN_W'(cnt_q) + span <= len_q) begin
            tbl_req.raddr_a = {lvl_q - LVL_W'(1), cnt_q};
            tbl_req.raddr_b = {lvl_q - LVL_W'(1), cnt_q + half[TOUR_W-1:0]};
            pend_d          = 1'b1;
            pend_addr_d     = {lvl_q, cnt_q};
            cnt_d           = cnt_q + CNT_W'(1);
          end else begin
            lvl_d = lvl_q + LVL_W'(1);
            cnt_d = '0;
          end
        end else begin
          built_d = 1'b1;
          state_d = S_RESP;
        end
      end
      S_Q1: begin
        tbl_req.raddr_a = {qlvl, pu};
        tbl_req.raddr_b = {qlvl, TOUR_W'(LEN_W'(pv) + LEN_W'(1) - (LEN_W'(1) << qlvl))};
        sum_d           = CNT_W'(depth_rd_a_q) + CNT_W'(depth_rd_b_q);
        state_d         = S_Q2;
      end
      S_Q2: begin
        res_anc_d  = tbl_pick.node;
        res_dist_d = (sum_q >= twice) ? sum_q - twice : '0;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_anc_d    = res_anc_q;
          out_dist_d   = res_dist_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // tour append
    if (app_en && len_q < LEN_W'(TOUR_MAX)) begin
      tbl_req.we    = 1'b1;
      tbl_req.waddr = {LVL_W'(0), len_q[TOUR_W-1:0]};
      tbl_req.wdata = '{depth: app_depth, node: app_node};
      tpos_we       = 1'b1;
      tpos_waddr    = app_node;
      tpos_wdata    = len_q[TOUR_W-1:0];
      len_d         = len_q + LEN_W'(1);
    end

    // sparse level write in the cycle after its reads
    if (pend_q) begin
      tbl_req.we    = 1'b1;
      tbl_req.waddr = pend_addr_q;
      tbl_req.wdata = tbl_pick;
    end

    if (cfg_we_i) begin
      built_d = 1'b0;
      case (cfg_reg_e'(cfg_idx_i))
        REG_NODE_COUNT: node_count_d = cfg_data_i;
        REG_ROOT_NODE:  root_d       = cfg_data_i[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready     = in_ready;
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.ancestor = out_anc_q;
  assign out_o.distance = out_dist_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= CNT_W'(MAX_NODES))
    else $error("walk stack overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LEN_W'(TOUR_MAX))
    else $error("tour length overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> !app_en)
    else $error("table write collision");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !edges_q[0] && edges_q <= EDGE_W'(EDGE_SLOTS))
    else $error("edge count corrupt");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while busy");

endmodule

### hdl/lca_table.sv
// sparse table memory of minimum depth with shared two-read minimum compare
module lca_table import lca_pkg::*; (
  input  logic       clk_i,
  input  tbl_req_t   req_i,
  output tbl_entry_t pick_o
);

  tbl_entry_t mem [TBL_DEPTH];
  tbl_entry_t rd_a_q;
  tbl_entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.raddr_a];
    rd_b_q <= mem[req_i.raddr_b];
  end

  assign pick_o = pick_min(rd_a_q, rd_b_q);

endmodule
